/* rtl/msp_pkg.sv */
// Shared types and constants for the motion spike / protect-mode detector.
// No dependencies; every other file imports this package.
package msp_pkg;

    // Default widths of one sample axis and of the millisecond timer.
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int TIME_WIDTH_DEF   = 32;

    // Spike counter width and its saturation value.
    localparam int         COUNT_WIDTH = 4;
    localparam logic [3:0] COUNT_MAX   = 4'd15;

    // Reset values of the configuration registers.
    localparam logic [63:0] THRESHOLD_SQ_RESET = 64'd32878756;
    localparam logic [3:0]  SPIKE_LIMIT_RESET  = 4'd3;
    localparam logic [63:0] COOLDOWN_MS_RESET  = 64'd600;

    // Configuration register indexes.
    localparam int CFG_INDEX_WIDTH = 2;
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_THRESHOLD_SQ = 2'd0,
        CFG_SPIKE_LIMIT  = 2'd1,
        CFG_COOLDOWN_MS  = 2'd2
    } cfg_index_t;

    // Event codes carried on the result channel.
    typedef enum logic [1:0] {
        EV_RESET          = 2'd0,
        EV_SPIKE          = 2'd1,
        EV_ENTER_PROTECT  = 2'd2,
        EV_PROTECT_ACTIVE = 2'd3
    } event_t;

    // Control part of one result word; payload travels beside it.
    typedef struct packed {
        event_t                 ev;
        logic                   mode;
        logic [COUNT_WIDTH-1:0] count;
        logic                   last;
    } res_ctrl_t;

endpackage

/* rtl/motion_spike_protect_detector.sv */
// Top level of the motion spike / protect-mode detector.
// Depends on msp_pkg, msp_cfg_regs, msp_eval and msp_out_queue.
//
//  Channel  | Direction | Handshake           | Contents
//  ---------+-----------+---------------------+--------------------------------------------
//  s_       | in        | s_tvalid / s_tready | tuser: action; tdata: accel x, y, z, now_ms
//  m_       | out       | m_tvalid / m_tready | tuser: event; tdata: mode, count, delta_sq,
//           |           |                     |   timestamp; tlast: final word of the item
//  cfg_     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// An input word is held in the input register; the squares, compares and state update
// are done combinationally from it, and its results enter the two-entry result queue.
// One input word per cycle is taken while the queue has room; a word that gives two results
// needs an empty queue after this cycle's pop, so it can wait behind a busy output.
// Reset (aresetn low, synchronous) clears mode, count, cooldown time and registers.
// A stall on m_tready backs up through the result queue into the input register.
module motion_spike_protect_detector
    import msp_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int TIME_WIDTH   = TIME_WIDTH_DEF,
    localparam int DELTA_WIDTH    = 2 * SAMPLE_WIDTH + 2,
    localparam int CFG_DATA_WIDTH = (DELTA_WIDTH > TIME_WIDTH) ? DELTA_WIDTH : TIME_WIDTH,
    localparam int IN_FIELDS_W    = 3 * SAMPLE_WIDTH + TIME_WIDTH,
    localparam int IN_TDATA_W     = ((IN_FIELDS_W + 7) / 8) * 8,
    localparam int OUT_FIELDS_W   = 1 + COUNT_WIDTH + DELTA_WIDTH + TIME_WIDTH,
    localparam int OUT_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // Input words.
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [IN_TDATA_W-1:0]      s_tdata,   // accel_x, accel_y, accel_z, now_ms, zero pad
    input  logic                       s_tuser,   // action
    // Result words.
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [OUT_TDATA_W-1:0]     m_tdata,   // mode, spike_count, delta_sq, timestamp, pad
    output logic [1:0]                 m_tuser,   // event_res
    output logic                       m_tlast,
    // Configuration writes.
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    logic                    in_valid_reg;
    logic                    action_reg;
    logic [IN_FIELDS_W-1:0]  fields_reg;
    logic                    advance;
    logic                    in_take;

    logic [DELTA_WIDTH-1:0]  threshold_sq;
    logic [COUNT_WIDTH-1:0]  spike_limit;
    logic [TIME_WIDTH-1:0]   cooldown_ms;

    logic [1:0]              res_count;
    res_ctrl_t               res0, res1;
    logic [DELTA_WIDTH-1:0]  delta_sq;
    logic [1:0]              remain;

    res_ctrl_t               out_res;
    logic [DELTA_WIDTH-1:0]  out_delta;
    logic [TIME_WIDTH-1:0]   out_time;

    logic signed [SAMPLE_WIDTH-1:0] accel_x, accel_y, accel_z;
    logic [TIME_WIDTH-1:0]          now_ms;

    assign cfg_ready = 1'b1;

    msp_cfg_regs #(
        .DELTA_WIDTH    (DELTA_WIDTH),
        .TIME_WIDTH     (TIME_WIDTH),
        .CFG_DATA_WIDTH (CFG_DATA_WIDTH)
    ) u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .wr_en        (cfg_valid),
        .wr_index     (cfg_index),
        .wr_data      (cfg_data),
        .threshold_sq (threshold_sq),
        .spike_limit  (spike_limit),
        .cooldown_ms  (cooldown_ms)
    );

    // The held word moves on when the queue has room for all of its results.
    assign advance  = in_valid_reg && (({1'b0, remain} + {1'b0, res_count}) <= 3'd2);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            action_reg <= s_tuser;
            fields_reg <= s_tdata[IN_FIELDS_W-1:0];
        end
    end

    assign accel_x = fields_reg[SAMPLE_WIDTH-1:0];
    assign accel_y = fields_reg[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
    assign accel_z = fields_reg[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH];
    assign now_ms  = fields_reg[IN_FIELDS_W-1:3*SAMPLE_WIDTH];

    msp_eval #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .TIME_WIDTH   (TIME_WIDTH),
        .DELTA_WIDTH  (DELTA_WIDTH)
    ) u_eval (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .action       (action_reg),
        .accel_x      (accel_x),
        .accel_y      (accel_y),
        .accel_z      (accel_z),
        .now_ms       (now_ms),
        .threshold_sq (threshold_sq),
        .spike_limit  (spike_limit),
        .cooldown_ms  (cooldown_ms),
        .res_count    (res_count),
        .res0         (res0),
        .res1         (res1),
        .delta_sq     (delta_sq)
    );

    msp_out_queue #(
        .DELTA_WIDTH (DELTA_WIDTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (advance),
        .push_count (res_count),
        .push_res0  (res0),
        .push_res1  (res1),
        .push_delta (delta_sq),
        .push_time  (now_ms),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_res    (out_res),
        .out_delta  (out_delta),
        .out_time   (out_time),
        .remain     (remain)
    );

    // Pack the head result onto the output channel.
    assign m_tdata = OUT_TDATA_W'({out_time, out_delta, out_res.count, out_res.mode});
    assign m_tuser = out_res.ev;
    assign m_tlast = out_res.last;

endmodule

/* rtl/msp_cfg_regs.sv */
// Configuration registers of the motion spike detector: threshold, limit, cooldown.
// Depends on msp_pkg for register indexes and reset values.
module msp_cfg_regs
    import msp_pkg::*;
#(
    parameter int DELTA_WIDTH    = 2 * SAMPLE_WIDTH_DEF + 2,
    parameter int TIME_WIDTH     = TIME_WIDTH_DEF,
    parameter int CFG_DATA_WIDTH = DELTA_WIDTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0] wr_index,
    input  logic [CFG_DATA_WIDTH-1:0]  wr_data,
    output logic [DELTA_WIDTH-1:0]     threshold_sq,
    output logic [COUNT_WIDTH-1:0]     spike_limit,
    output logic [TIME_WIDTH-1:0]      cooldown_ms
);

    logic [DELTA_WIDTH-1:0] threshold_reg;
    logic [COUNT_WIDTH-1:0] limit_reg;
    logic [TIME_WIDTH-1:0]  cooldown_reg;

    // Registers take a write by index; an index past the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= DELTA_WIDTH'(THRESHOLD_SQ_RESET);
            limit_reg     <= SPIKE_LIMIT_RESET;
            cooldown_reg  <= TIME_WIDTH'(COOLDOWN_MS_RESET);
        end else if (wr_en) begin
            unique case (wr_index)
                CFG_THRESHOLD_SQ: threshold_reg <= wr_data[DELTA_WIDTH-1:0];
                CFG_SPIKE_LIMIT:  limit_reg     <= wr_data[COUNT_WIDTH-1:0];
                CFG_COOLDOWN_MS:  cooldown_reg  <= wr_data[TIME_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign threshold_sq = threshold_reg;
    assign spike_limit  = limit_reg;
    assign cooldown_ms  = cooldown_reg;

endmodule

/* rtl/msp_eval.sv */
// Per-word evaluation: squared change, threshold and cooldown test, mode and count state.
// Depends on msp_pkg for event codes and the result control struct.
module msp_eval
    import msp_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int TIME_WIDTH   = TIME_WIDTH_DEF,
    parameter int DELTA_WIDTH  = 2 * SAMPLE_WIDTH + 2
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           advance,
    input  logic                           action,
    input  logic signed [SAMPLE_WIDTH-1:0] accel_x,
    input  logic signed [SAMPLE_WIDTH-1:0] accel_y,
    input  logic signed [SAMPLE_WIDTH-1:0] accel_z,
    input  logic [TIME_WIDTH-1:0]          now_ms,
    input  logic [DELTA_WIDTH-1:0]         threshold_sq,
    input  logic [COUNT_WIDTH-1:0]         spike_limit,
    input  logic [TIME_WIDTH-1:0]          cooldown_ms,
    output logic [1:0]                     res_count,
    output res_ctrl_t                      res0,
    output res_ctrl_t                      res1,
    output logic [DELTA_WIDTH-1:0]         delta_sq
);

    logic                           mode_reg;
    logic [COUNT_WIDTH-1:0]         count_reg;
    logic [TIME_WIDTH-1:0]          last_spike_reg;
    logic                           have_prev_reg;
    logic signed [SAMPLE_WIDTH-1:0] prev_x_reg, prev_y_reg, prev_z_reg;

    logic signed [SAMPLE_WIDTH:0]  diff_x, diff_y, diff_z;
    logic signed [DELTA_WIDTH-1:0] sq_x, sq_y, sq_z;
    logic [DELTA_WIDTH-1:0]        delta_sum;
    logic [TIME_WIDTH-1:0]         elapsed;
    logic                          spike;
    logic [COUNT_WIDTH-1:0]        count_inc;
    logic                          enter;

    // Differences against the stored sample, one extra bit for the range.
    assign diff_x = {accel_x[SAMPLE_WIDTH-1], accel_x} - {prev_x_reg[SAMPLE_WIDTH-1], prev_x_reg};
    assign diff_y = {accel_y[SAMPLE_WIDTH-1], accel_y} - {prev_y_reg[SAMPLE_WIDTH-1], prev_y_reg};
    assign diff_z = {accel_z[SAMPLE_WIDTH-1], accel_z} - {prev_z_reg[SAMPLE_WIDTH-1], prev_z_reg};

    // Three independent squares; each is non-negative, so the sum fits unsigned.
    assign sq_x      = DELTA_WIDTH'(diff_x) * DELTA_WIDTH'(diff_x);
    assign sq_y      = DELTA_WIDTH'(diff_y) * DELTA_WIDTH'(diff_y);
    assign sq_z      = DELTA_WIDTH'(diff_z) * DELTA_WIDTH'(diff_z);
    assign delta_sum = $unsigned(sq_x) + $unsigned(sq_y) + $unsigned(sq_z);

    // Elapsed time since the last detected spike wraps with the timer.
    assign elapsed = now_ms - last_spike_reg;

    assign spike = !action && have_prev_reg && (delta_sum >= threshold_sq)
                   && (elapsed >= cooldown_ms);
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_WIDTH'(1);
    assign enter     = spike && !mode_reg && (count_inc >= spike_limit);

    // Result words produced by this input word.
    always_comb begin
        res0      = '{ev: EV_PROTECT_ACTIVE, mode: 1'b1, count: count_reg, last: 1'b1};
        res1      = '{ev: EV_ENTER_PROTECT, mode: 1'b1, count: count_inc, last: 1'b1};
        res_count = 2'd0;
        if (action) begin
            res0      = '{ev: EV_RESET, mode: 1'b0, count: '0, last: 1'b1};
            res_count = 2'd1;
        end else if (spike && !mode_reg) begin
            res0      = '{ev: EV_SPIKE, mode: 1'b0, count: count_inc, last: !enter};
            res_count = enter ? 2'd2 : 2'd1;
        end else if (spike) begin
            res_count = 2'd1;
        end
    end

    assign delta_sq = action ? '0 : delta_sum;

    // Mode, count and timing state advance with each consumed word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= 1'b0;
            count_reg      <= '0;
            last_spike_reg <= '0;
            have_prev_reg  <= 1'b0;
        end else if (advance) begin
            if (action) begin
                mode_reg  <= 1'b0;
                count_reg <= '0;
            end else begin
                have_prev_reg <= 1'b1;
                if (spike) begin
                    last_spike_reg <= now_ms;
                    if (!mode_reg) begin
                        count_reg <= count_inc;
                    end
                    if (enter) begin
                        mode_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // The previous sample is only read once have_prev_reg is set.
    always_ff @(posedge aclk) begin
        if (advance && !action) begin
            prev_x_reg <= accel_x;
            prev_y_reg <= accel_y;
            prev_z_reg <= accel_z;
        end
    end

endmodule

/* rtl/msp_out_queue.sv */
// Two-entry result queue that feeds the output channel, up to two words per push.
// Depends on msp_pkg for the result control struct.
module msp_out_queue
    import msp_pkg::*;
#(
    parameter int DELTA_WIDTH = 2 * SAMPLE_WIDTH_DEF + 2,
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  logic [1:0]             push_count,
    input  res_ctrl_t              push_res0,
    input  res_ctrl_t              push_res1,
    input  logic [DELTA_WIDTH-1:0] push_delta,
    input  logic [TIME_WIDTH-1:0]  push_time,
    input  logic                   out_ready,
    output logic                   out_valid,
    output res_ctrl_t              out_res,
    output logic [DELTA_WIDTH-1:0] out_delta,
    output logic [TIME_WIDTH-1:0]  out_time,
    output logic [1:0]             remain
);

    logic [1:0]             cnt_reg, cnt_next;
    res_ctrl_t              res0_reg, res1_reg, res0_next, res1_next;
    logic [DELTA_WIDTH-1:0] delta0_reg, delta1_reg, delta0_next, delta1_next;
    logic [TIME_WIDTH-1:0]  time0_reg, time1_reg, time0_next, time1_next;
    logic                   pop;
    logic [1:0]             added;

    assign pop    = (cnt_reg != 2'd0) && out_ready;
    assign remain = cnt_reg - {1'b0, pop};
    assign added  = push ? push_count : 2'd0;

    // Entries left after the pop stay at the head; new words fill in behind.
    always_comb begin
        res0_next   = res0_reg;
        res1_next   = res1_reg;
        delta0_next = delta0_reg;
        delta1_next = delta1_reg;
        time0_next  = time0_reg;
        time1_next  = time1_reg;
        case (remain)
            2'd0: begin
                res0_next   = push_res0;
                res1_next   = push_res1;
                delta0_next = push_delta;
                delta1_next = push_delta;
                time0_next  = push_time;
                time1_next  = push_time;
            end
            2'd1: begin
                if (pop) begin
                    res0_next   = res1_reg;
                    delta0_next = delta1_reg;
                    time0_next  = time1_reg;
                end
                res1_next   = push_res0;
                delta1_next = push_delta;
                time1_next  = push_time;
            end
            default: ;
        endcase
        cnt_next = remain + added;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        res0_reg   <= res0_next;
        res1_reg   <= res1_next;
        delta0_reg <= delta0_next;
        delta1_reg <= delta1_next;
        time0_reg  <= time0_next;
        time1_reg  <= time1_next;
    end

    assign out_valid = cnt_reg != 2'd0;
    assign out_res   = res0_reg;
    assign out_delta = delta0_reg;
    assign out_time  = time0_reg;

endmodule

/* rtl/msp_checker.sv */
// Port-level checks on the result channel of the motion spike detector, bound to the top.
// Depends on msp_pkg for event codes.
module msp_checker
    import msp_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int TIME_WIDTH   = TIME_WIDTH_DEF,
    localparam int OUT_FIELDS_W = 1 + COUNT_WIDTH + 2 * SAMPLE_WIDTH + 2 + TIME_WIDTH,
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic [1:0]             m_tuser,
    input logic                   m_tlast
);

    // A stalled word holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result word changed while stalled");

    // A spike that is not the item's final word is followed at once by enter protect.
    a_enter_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser == EV_SPIKE && !m_tlast
            |=> m_tvalid && m_tuser == EV_ENTER_PROTECT)
        else $error("spike word without final mark not followed by enter protect");

    // Entering protect closes the item and reports protect mode.
    a_enter_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == EV_ENTER_PROTECT |-> m_tlast && m_tdata[0])
        else $error("enter protect word with wrong mode or final mark");

    // A reset result shows monitoring mode, a cleared count and zero change.
    a_reset_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == EV_RESET
            |-> m_tlast && !m_tdata[0] && m_tdata[COUNT_WIDTH:1] == '0
                && m_tdata[COUNT_WIDTH+2*SAMPLE_WIDTH+2:COUNT_WIDTH+1] == '0)
        else $error("reset word with nonzero state");

endmodule

bind motion_spike_protect_detector msp_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .TIME_WIDTH   (TIME_WIDTH)
) u_msp_checker (.*);
